// ===== rtl/hlxd_pkg.sv =====
// Package for the header/length/XOR packet deframer.
// Holds the header byte constants, register indexes and the
// controller-to-datapath command and status structs. No dependencies.
package hlxd_pkg;

    // Header bytes, in order: 'U' 'N' 'E' 'R'
    localparam logic [7:0] HDR_U = 8'h55;
    localparam logic [7:0] HDR_N = 8'h4E;
    localparam logic [7:0] HDR_E = 8'h45;
    localparam logic [7:0] HDR_R = 8'h52;

    // Smallest length byte that leaves room for a command
    localparam logic [7:0] MIN_LEN = 8'd2;

    // Register indexes (paddr[2])
    localparam logic REG_TOKEN   = 1'b0;
    localparam logic REG_DELIVER = 1'b1;

    // Reset values of the registers
    localparam logic [7:0] TOKEN_RESET   = 8'd58;
    localparam logic       DELIVER_RESET = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic xor_load;     // start the running check with this byte
        logic xor_acc;      // fold this byte into the running check
        logic len_load;     // take the length byte, clear the write index
        logic cmd_load;     // capture the command byte
        logic rem_dec;      // one body byte consumed
        logic store_wr;     // write this byte into the payload store
        logic rd_clear;     // restart the drain index
        logic rd_step;      // advance the drain index
        logic out_load;     // load the output register
        logic out_has_data; // the loaded item carries a payload byte
    } hlxd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic eq_u;
        logic eq_n;
        logic eq_e;
        logic eq_r;
        logic len_ok;      // length byte inside the accepted range
        logic token_ok;    // byte matches the token register
        logic rem_last;    // this body byte is the checksum byte
        logic check_ok;    // running check XOR this byte is zero
        logic deliver_en;  // delivery enabled
        logic count_zero;  // frame has an empty payload
        logic rd_last;     // drain index is on the final payload byte
        logic out_free;    // output register can take an item this cycle
    } hlxd_sts_t;

endpackage

// ===== rtl/hlxd_ctrl.sv =====
// Controller of the deframer: header hunt, length/token checks, body
// receive and the drain sequence that emits result items.
// Depends on hlxd_pkg.
module hlxd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hlxd_pkg::hlxd_sts_t sts,
    output hlxd_pkg::hlxd_cmd_t cmd
);
    import hlxd_pkg::*;

    localparam logic [3:0] ST_HUNT   = 4'd0;
    localparam logic [3:0] ST_H1     = 4'd1;
    localparam logic [3:0] ST_H2     = 4'd2;
    localparam logic [3:0] ST_H3     = 4'd3;
    localparam logic [3:0] ST_LEN    = 4'd4;
    localparam logic [3:0] ST_TOKEN  = 4'd5;
    localparam logic [3:0] ST_CMD    = 4'd6;
    localparam logic [3:0] ST_BODY   = 4'd7;
    localparam logic [3:0] ST_D_ADDR = 4'd8;
    localparam logic [3:0] ST_D_LOAD = 4'd9;
    localparam logic [3:0] ST_D_EMPTY = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       fire;

    // Bytes are taken in every parse state, never while draining
    assign s_ready = (state_reg <= ST_BODY);
    assign fire    = s_valid && s_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT: begin
                if (fire && sts.eq_u) begin
                    cmd.xor_load = 1'b1;
                    state_next   = ST_H1;
                end
            end
            ST_H1: begin
                if (fire) begin
                    cmd.xor_acc = sts.eq_n;
                    state_next  = sts.eq_n ? ST_H2 : ST_HUNT;
                end
            end
            ST_H2: begin
                if (fire) begin
                    cmd.xor_acc = sts.eq_e;
                    state_next  = sts.eq_e ? ST_H3 : ST_HUNT;
                end
            end
            ST_H3: begin
                if (fire) begin
                    cmd.xor_acc = sts.eq_r;
                    state_next  = sts.eq_r ? ST_LEN : ST_HUNT;
                end
            end
            ST_LEN: begin
                if (fire) begin
                    cmd.xor_acc  = sts.len_ok;
                    cmd.len_load = sts.len_ok;
                    state_next   = sts.len_ok ? ST_TOKEN : ST_HUNT;
                end
            end
            ST_TOKEN: begin
                if (fire) begin
                    cmd.xor_acc = sts.token_ok;
                    state_next  = sts.token_ok ? ST_CMD : ST_HUNT;
                end
            end
            ST_CMD: begin
                // Length is at least two, so a checksum byte always follows
                if (fire) begin
                    cmd.xor_acc  = 1'b1;
                    cmd.cmd_load = 1'b1;
                    cmd.rem_dec  = 1'b1;
                    state_next   = ST_BODY;
                end
            end
            ST_BODY: begin
                if (fire) begin
                    cmd.xor_acc  = 1'b1;
                    cmd.rem_dec  = 1'b1;
                    cmd.store_wr = !sts.rem_last;
                    if (sts.rem_last) begin
                        if (sts.check_ok && sts.deliver_en) begin
                            cmd.rd_clear = 1'b1;
                            state_next   = sts.count_zero ? ST_D_EMPTY : ST_D_ADDR;
                        end else begin
                            state_next = ST_HUNT;
                        end
                    end
                end
            end
            ST_D_ADDR: begin
                // Store read is in flight this cycle
                state_next = ST_D_LOAD;
            end
            ST_D_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_has_data = 1'b1;
                    cmd.rd_step      = 1'b1;
                    state_next       = sts.rd_last ? ST_HUNT : ST_D_ADDR;
                end
            end
            ST_D_EMPTY: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_HUNT;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/hlxd_dpath.sv =====
// Datapath of the deframer: running XOR check, length and index counters,
// command capture, payload store and the output register.
// Depends on hlxd_pkg.
module hlxd_dpath #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          token_value,
    input  logic                deliver_enable,
    input  hlxd_pkg::hlxd_cmd_t cmd,
    output hlxd_pkg::hlxd_sts_t sts,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [7:0]          m_command,
    output logic [7:0]          m_data_byte,
    output logic                m_has_data,
    output logic [5:0]          m_payload_count,
    output logic                m_last
);
    import hlxd_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [8:0] MAX_LEN = 9'(BUFFER_DEPTH + 1);

    logic [7:0]    check_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    count_reg;
    logic [7:0]    command_reg;
    logic [AW-1:0] wr_idx_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    store_mem [BUFFER_DEPTH];

    logic          out_valid_reg;
    logic [7:0]    out_command_reg;
    logic [7:0]    out_data_reg;
    logic          out_has_data_reg;
    logic [5:0]    out_count_reg;
    logic          out_last_reg;

    // Status toward the controller
    always_comb begin
        sts.eq_u       = (rx_byte == HDR_U);
        sts.eq_n       = (rx_byte == HDR_N);
        sts.eq_e       = (rx_byte == HDR_E);
        sts.eq_r       = (rx_byte == HDR_R);
        sts.len_ok     = (rx_byte >= MIN_LEN) && ({1'b0, rx_byte} <= MAX_LEN);
        sts.token_ok   = (rx_byte == token_value);
        sts.rem_last   = (rem_reg == 8'd1);
        sts.check_ok   = (check_reg == rx_byte);
        sts.deliver_en = deliver_enable;
        sts.count_zero = (count_reg == 8'd0);
        sts.rd_last    = ((8'(rd_idx_reg) + 8'd1) == count_reg);
        sts.out_free   = !out_valid_reg || m_ready;
    end

    // Running check, counters and command byte
    always_ff @(posedge aclk) begin
        if (cmd.xor_load) begin
            check_reg <= rx_byte;
        end else if (cmd.xor_acc) begin
            check_reg <= check_reg ^ rx_byte;
        end
        if (cmd.len_load) begin
            rem_reg    <= rx_byte;
            count_reg  <= rx_byte - MIN_LEN;
            wr_idx_reg <= '0;
        end else begin
            if (cmd.rem_dec) begin
                rem_reg <= rem_reg - 8'd1;
            end
            if (cmd.store_wr) begin
                wr_idx_reg <= AW'(wr_idx_reg + 1'b1);
            end
        end
        if (cmd.cmd_load) begin
            command_reg <= rx_byte;
        end
        if (cmd.rd_clear) begin
            rd_idx_reg <= '0;
        end else if (cmd.rd_step) begin
            rd_idx_reg <= AW'(rd_idx_reg + 1'b1);
        end
    end

    // Payload store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.store_wr) begin
            store_mem[wr_idx_reg] <= rx_byte;
        end
        rd_data_reg <= store_mem[rd_idx_reg];
    end

    // Output register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_command_reg  <= command_reg;
            out_data_reg     <= cmd.out_has_data ? rd_data_reg : 8'd0;
            out_has_data_reg <= cmd.out_has_data;
            out_count_reg    <= count_reg[5:0];
            out_last_reg     <= cmd.out_has_data ? sts.rd_last : 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_command       = out_command_reg;
    assign m_data_byte     = out_data_reg;
    assign m_has_data      = out_has_data_reg;
    assign m_payload_count = out_count_reg;
    assign m_last          = out_last_reg;

endmodule

// ===== rtl/header_length_xor_packet_deframer_core.sv =====
// Top level of the header/length/XOR packet deframer: register port,
// controller and datapath.
// Depends on hlxd_pkg, hlxd_ctrl and hlxd_dpath.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ------------------------------------------
//   s_        s_valid / s_ready    s_rx_byte
//   m_        m_valid / m_ready    m_command, m_data_byte, m_has_data,
//                                  m_payload_count, m_last
//   APB       psel/penable/pready  paddr 0: token_value, paddr 4: deliver_enable
//
// A byte is taken whenever s_valid and s_ready are both high. A frame that
// passes its checks is then drained one payload byte at a time (store read,
// then output load), or as one item without data for an empty payload;
// s_ready is low while draining. The output register lets the next frame's
// bytes in while the final item waits. A stalled m_ready holds the drain.
// Reset is synchronous on aresetn; the payload store needs no clearing.
module header_length_xor_packet_deframer_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // Result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_command,
    output logic [7:0]  m_data_byte,
    output logic        m_has_data,
    output logic [5:0]  m_payload_count,
    output logic        m_last,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hlxd_pkg::*;

    logic       token_sel;
    logic [7:0] token_value_reg;
    logic       deliver_reg;
    logic       wr_en;
    hlxd_cmd_t  cmd;
    hlxd_sts_t  sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_value_reg <= TOKEN_RESET;
            deliver_reg     <= DELIVER_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TOKEN:   token_value_reg <= pwdata[7:0];
                REG_DELIVER: deliver_reg     <= pwdata[0];
                default:     token_value_reg <= token_value_reg;
            endcase
        end
    end

    // Register reads
    assign token_sel = (paddr[2] == REG_TOKEN);
    assign prdata    = token_sel ? {24'd0, token_value_reg} : {31'd0, deliver_reg};

    hlxd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hlxd_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rx_byte         (s_rx_byte),
        .token_value     (token_value_reg),
        .deliver_enable  (deliver_reg),
        .cmd             (cmd),
        .sts             (sts),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_command       (m_command),
        .m_data_byte     (m_data_byte),
        .m_has_data      (m_has_data),
        .m_payload_count (m_payload_count),
        .m_last          (m_last)
    );

endmodule
